// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent check forms, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every edge
`define ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/ngfe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ngfe_pkg
// constants, types and helpers shared by the gga field extractor
// ----------------------------------------------------------------------------
package ngfe_pkg;

	localparam int FIELD_CHARS = 16;
	localparam int NUM_BUFS    = 3;
	localparam int NUM_BANKS   = 2;
	localparam int STORE_DEPTH = NUM_BUFS * FIELD_CHARS;
	localparam int MEM_DEPTH   = NUM_BANKS * STORE_DEPTH;
	localparam int ADDR_W      = $clog2(MEM_DEPTH);
	localparam int LEN_W       = $clog2(FIELD_CHARS + 1);
	localparam int IDX_W       = $clog2(FIELD_CHARS);
	localparam int PREFIX_LEN  = 6;
	localparam int CMDQ_DEPTH  = 2;
	localparam int CMDQ_PTR_W  = $clog2(CMDQ_DEPTH);
	localparam int CMDQ_CNT_W  = $clog2(CMDQ_DEPTH + 1);

	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_G      = 8'h47;
	localparam logic [7:0] CH_P      = 8'h50;
	localparam logic [7:0] CH_A      = 8'h41;
	localparam logic [7:0] CH_NUL    = 8'h00;

	localparam logic [3:0] FIELD_LAT  = 4'd2;
	localparam logic [3:0] FIELD_LON  = 4'd4;
	localparam logic [3:0] FIELD_ALT  = 4'd9;
	localparam logic [3:0] FIELD_UNIT = 4'd10;
	localparam logic [3:0] FIELD_MAX  = 4'd15;

	typedef logic [1:0]        buf_id_t;
	typedef logic [LEN_W-1:0]  len_t;
	typedef logic [IDX_W-1:0]  idx_t;
	typedef logic [ADDR_W-1:0] addr_t;

	localparam buf_id_t BUF_LAT = 2'd0;
	localparam buf_id_t BUF_LON = 2'd1;
	localparam buf_id_t BUF_ALT = 2'd2;

	// one finished sentence handed to the back end
	typedef struct packed {
		logic                       bank;
		len_t [NUM_BUFS-1:0]        lens;
		logic [NUM_BUFS-1:0]        ovf;
	} cmd_t;

	// store write port from the front end
	typedef struct packed {
		logic  en;
		addr_t addr;
		logic [7:0] data;
	} wr_t;

	// queue status
	typedef struct packed {
		logic                  full;
		logic                  empty;
		logic [CMDQ_CNT_W-1:0] count;
	} q_stat_t;

	typedef struct packed {
		logic    hit;
		buf_id_t slot;
	} slot_sel_t;

	function automatic logic [7:0] prefix_char(input logic [2:0] pos);
		logic [7:0] ch;
		case (pos)
			3'd0: ch = CH_DOLLAR;
			3'd1: ch = CH_G;
			3'd2: ch = CH_P;
			3'd3: ch = CH_G;
			3'd4: ch = CH_G;
			3'd5: ch = CH_A;
			default: ch = CH_NUL;
		endcase
		return ch;
	endfunction

	function automatic slot_sel_t buffer_for_field(input logic [3:0] f);
		slot_sel_t s;
		s.hit  = 1'b1;
		s.slot = BUF_LAT;
		if (f == FIELD_LAT) begin
			s.slot = BUF_LAT;
		end else if (f == FIELD_LON) begin
			s.slot = BUF_LON;
		end else if (f == FIELD_ALT || f == FIELD_UNIT) begin
			s.slot = BUF_ALT;
		end else begin
			s.hit = 1'b0;
		end
		return s;
	endfunction

	function automatic addr_t store_addr(input logic bank, input buf_id_t slot,
		input idx_t idx);
		return ADDR_W'(bank) * ADDR_W'(STORE_DEPTH)
			+ ADDR_W'(slot) * ADDR_W'(FIELD_CHARS)
			+ ADDR_W'(idx);
	endfunction

endpackage

// ===== src/ngfe_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ngfe_in_if
// byte request channel into the extractor
// ----------------------------------------------------------------------------
interface ngfe_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source(output valid, output rx_byte, input ready);
	modport sink(input valid, input rx_byte, output ready);
endinterface

// ===== src/ngfe_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ngfe_out_if
// tagged character request channel out of the extractor
// ----------------------------------------------------------------------------
interface ngfe_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] field_id;
	logic [7:0] char_code;
	logic       char_valid;
	logic       truncated;
	logic       last;

	modport source(output valid, output field_id, output char_code, output char_valid,
		output truncated, output last, input ready);
	modport sink(input valid, input field_id, input char_code, input char_valid,
		input truncated, input last, output ready);
endinterface

// ===== src/ngfe_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ngfe_front
// sentence parser: prefix match, field counting, capture into the store
// ----------------------------------------------------------------------------
module ngfe_front (
	input  logic            clk,
	input  logic            arst_n,
	ngfe_in_if.sink         rx,
	input  logic            bank_free,
	output ngfe_pkg::wr_t   wr,
	output logic            cmd_push,
	output ngfe_pkg::cmd_t  cmd
);
	import ngfe_pkg::*;

	logic [2:0]          pos_q;
	logic                matched_q;
	logic [3:0]          fcnt_q;
	len_t [NUM_BUFS-1:0] lens_q;
	logic [NUM_BUFS-1:0] ovf_q;
	logic                bank_q;

	logic       accept;
	logic [7:0] c;
	logic       is_dollar;
	logic       in_body;
	logic       is_star;
	logic       is_comma;
	logic       is_char;
	slot_sel_t  sel;
	len_t       cur_len;
	logic       has_room;

	assign rx.ready  = bank_free;
	assign accept    = rx.valid && rx.ready;
	assign c         = rx.rx_byte;
	assign is_dollar = (c == CH_DOLLAR);
	assign in_body   = accept && !is_dollar && (pos_q != 3'd0) && matched_q;
	assign is_star   = (c == CH_STAR);
	assign is_comma  = (c == CH_COMMA);
	assign is_char   = in_body && !is_star && !is_comma;
	assign sel       = buffer_for_field(fcnt_q);
	assign cur_len   = sel.hit ? lens_q[sel.slot] : '0;
	assign has_room  = (cur_len != LEN_W'(FIELD_CHARS));

	assign wr.en    = is_char && sel.hit && has_room;
	assign wr.addr  = store_addr(bank_q, sel.slot, cur_len[IDX_W-1:0]);
	assign wr.data  = c;

	assign cmd_push = in_body && is_star;
	assign cmd.bank = bank_q;
	assign cmd.lens = lens_q;
	assign cmd.ovf  = ovf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			matched_q <= 1'b0;
			fcnt_q    <= '0;
			lens_q    <= '0;
			ovf_q     <= '0;
			bank_q    <= 1'b0;
		end else if (accept) begin
			if (is_dollar) begin
				pos_q     <= 3'd1;
				matched_q <= 1'b0;
				fcnt_q    <= '0;
				lens_q    <= '0;
				ovf_q     <= '0;
			end else if (pos_q == 3'd0) begin
				pos_q <= pos_q;
			end else if (!matched_q) begin
				if (pos_q < 3'(PREFIX_LEN) && c == prefix_char(pos_q)) begin
					pos_q     <= pos_q + 3'd1;
					matched_q <= (pos_q == 3'(PREFIX_LEN - 1));
				end else begin
					pos_q <= '0;
				end
			end else if (is_star) begin
				pos_q     <= '0;
				matched_q <= 1'b0;
				bank_q    <= ~bank_q;
			end else if (is_comma) begin
				if (fcnt_q != FIELD_MAX) begin
					fcnt_q <= fcnt_q + 4'd1;
				end
			end else if (sel.hit) begin
				if (has_room) begin
					lens_q[sel.slot] <= cur_len + len_t'(1);
				end else begin
					ovf_q[sel.slot] <= 1'b1;
				end
			end
		end
	end

endmodule

// ===== src/ngfe_cmd_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ngfe_cmd_fifo
// short queue of finished sentences between parser and emitter
// ----------------------------------------------------------------------------
module ngfe_cmd_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  ngfe_pkg::cmd_t      push_data,
	input  logic                pop,
	output ngfe_pkg::cmd_t      head,
	output ngfe_pkg::q_stat_t   stat
);
	import ngfe_pkg::*;

`include "assert_macros.svh"

	cmd_t                  entries_q [CMDQ_DEPTH];
	logic [CMDQ_PTR_W-1:0] wptr_q;
	logic [CMDQ_PTR_W-1:0] rptr_q;
	logic [CMDQ_CNT_W-1:0] count_q;

	function automatic logic [CMDQ_PTR_W-1:0] ptr_next(input logic [CMDQ_PTR_W-1:0] p);
		return (p == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : p + CMDQ_PTR_W'(1);
	endfunction

	assign head       = entries_q[rptr_q];
	assign stat.count = count_q;
	assign stat.full  = (count_q == CMDQ_CNT_W'(CMDQ_DEPTH));
	assign stat.empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= ptr_next(wptr_q);
			end
			if (pop) begin
				rptr_q <= ptr_next(rptr_q);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + CMDQ_CNT_W'(1);
				2'b01:   count_q <= count_q - CMDQ_CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	`ASSERT_IMPLIES(a_no_push_full, push, !stat.full || pop, "push into full queue")
	`ASSERT_IMPLIES(a_no_pop_empty, pop, !stat.empty, "pop from empty queue")
	`ASSERT_ALWAYS(a_count_range, count_q <= CMDQ_CNT_W'(CMDQ_DEPTH), "queue count overrun")

endmodule

// ===== src/ngfe_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ngfe_back
// emitter: holds the two-bank character store and drains one sentence
// ----------------------------------------------------------------------------
module ngfe_back (
	input  logic               clk,
	input  logic               arst_n,
	input  ngfe_pkg::wr_t      wr,
	input  ngfe_pkg::cmd_t     head,
	input  ngfe_pkg::q_stat_t  stat,
	output logic               pop,
	output logic               busy,
	ngfe_out_if.source         res
);
	import ngfe_pkg::*;

`include "assert_macros.svh"

	typedef enum logic [3:0] {
		B_IDLE  = 4'b0001,
		B_FETCH = 4'b0010,
		B_LOAD  = 4'b0100,
		B_HOLD  = 4'b1000
	} back_state_t;

	logic [7:0]  mem_q [MEM_DEPTH];
	logic [7:0]  rdata_q;

	back_state_t state_q;
	cmd_t        cmd_q;
	buf_id_t     buf_q;
	idx_t        idx_q;

	logic        vld_q;
	buf_id_t     id_q;
	logic [7:0]  code_q;
	logic        cv_q;
	logic        tr_q;
	logic        last_q;

	addr_t       rd_addr;
	len_t        cur_len;
	logic        buf_empty;
	logic        at_end;
	logic        buf_last;

	assign rd_addr   = store_addr(cmd_q.bank, buf_q, idx_q);
	assign cur_len   = cmd_q.lens[buf_q];
	assign buf_empty = (cur_len == '0);
	assign at_end    = buf_empty || ((LEN_W'(idx_q) + LEN_W'(1)) == cur_len);
	assign buf_last  = (buf_q == BUF_ALT);

	assign pop  = (state_q == B_IDLE) && !stat.empty;
	assign busy = (state_q != B_IDLE);

	assign res.valid      = vld_q;
	assign res.field_id   = id_q;
	assign res.char_code  = code_q;
	assign res.char_valid = cv_q;
	assign res.truncated  = tr_q;
	assign res.last       = last_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem_q[rd_addr];
	end

	// payload of the output register, and the sentence command taken on pop
	always_ff @(posedge clk) begin
		if (state_q == B_LOAD) begin
			id_q   <= buf_q;
			code_q <= buf_empty ? CH_NUL : rdata_q;
			cv_q   <= !buf_empty;
			tr_q   <= cmd_q.ovf[buf_q];
			last_q <= buf_last && at_end;
		end
		if (pop) begin
			cmd_q <= head;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			buf_q   <= '0;
			idx_q   <= '0;
			vld_q   <= 1'b0;
		end else begin
			case (state_q)
				B_IDLE: begin
					if (!stat.empty) begin
						buf_q   <= BUF_LAT;
						idx_q   <= '0;
						state_q <= B_FETCH;
					end
				end
				B_FETCH: begin
					state_q <= B_LOAD;
				end
				B_LOAD: begin
					vld_q   <= 1'b1;
					state_q <= B_HOLD;
				end
				B_HOLD: begin
					if (res.ready) begin
						vld_q <= 1'b0;
						if (last_q) begin
							state_q <= B_IDLE;
						end else if (at_end) begin
							buf_q   <= buf_q + buf_id_t'(1);
							idx_q   <= '0;
							state_q <= B_FETCH;
						end else begin
							idx_q   <= idx_q + idx_t'(1);
							state_q <= B_FETCH;
						end
					end
				end
				default: begin
					state_q <= B_IDLE;
					vld_q   <= 1'b0;
				end
			endcase
		end
	end

	`ASSERT_IMPLIES(a_vld_in_hold, vld_q, state_q == B_HOLD, "result shown outside hold")
	`ASSERT_NEXT(a_last_ends, res.valid && res.ready && res.last, state_q == B_IDLE, "burst did not end on last")
	`ASSERT_IMPLIES(a_idx_in_len, (state_q == B_LOAD) && !buf_empty, LEN_W'(idx_q) < cur_len, "read past field length")

endmodule

// ===== src/nmea_gga_field_extractor_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmea_gga_field_extractor_unit
// parses $GPGGA sentences byte by byte and emits latitude, longitude and
// altitude with unit as tagged characters when the sentence ends on '*'
// ----------------------------------------------------------------------------
//  channel  dir  payload                                          handshake
//  rx       in   rx_byte[7:0]                                     valid/ready
//  res      out  field_id[1:0] char_code[7:0] char_valid          valid/ready
//                truncated last
//
//  rx takes one byte per cycle while a store bank is free for the parser.
//  each result passes through a store read, an output load and a handshake;
//  the next result is not read until the sink has taken the one before.
//  the parser fills one store bank while the emitter drains the other; rx
//  stalls only when both banks hold sentences not yet drained.
// ----------------------------------------------------------------------------
module nmea_gga_field_extractor_unit (
	input  logic        clk,
	input  logic        arst_n,
	ngfe_in_if.sink     rx,
	ngfe_out_if.source  res
);
	import ngfe_pkg::*;

	wr_t     wr;
	logic    cmd_push;
	cmd_t    cmd;
	cmd_t    head;
	q_stat_t stat;
	logic    pop;
	logic    busy;
	logic    bank_free;
	logic [CMDQ_CNT_W:0] owned;

	// banks held by queued or draining sentences
	assign owned     = {1'b0, stat.count} + {{CMDQ_CNT_W{1'b0}}, busy};
	assign bank_free = (owned < (CMDQ_CNT_W + 1)'(NUM_BANKS));

	ngfe_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx       (rx),
		.bank_free(bank_free),
		.wr       (wr),
		.cmd_push (cmd_push),
		.cmd      (cmd)
	);

	ngfe_cmd_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (cmd_push),
		.push_data(cmd),
		.pop      (pop),
		.head     (head),
		.stat     (stat)
	);

	ngfe_back u_back (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (wr),
		.head  (head),
		.stat  (stat),
		.pop   (pop),
		.busy  (busy),
		.res   (res)
	);

endmodule

// ===== verif/nmea_gga_field_extractor_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmea_gga_field_extractor_unit_tb
// streams short directed and random $GPGGA sentences, broken prefixes, aborted
// sentences and line noise into the extractor under random valid and ready
// gaps, and checks every tagged character against a parser model kept here
// ----------------------------------------------------------------------------
module nmea_gga_field_extractor_unit_tb;
	import ngfe_pkg::*;

	typedef struct packed {
		buf_id_t    fid;
		logic [7:0] code;
		logic       cv;
		logic       trunc;
		logic       last;
	} glyph_t;

	typedef enum int unsigned {
		KIND_PLAIN   = 0,
		KIND_LONG    = 1,
		KIND_MANY    = 2,
		KIND_ABORT   = 3,
		KIND_BAD_TAG = 4,
		KIND_TAIL    = 5
	} gga_kind_e;

	localparam int BYTE_BUDGET  = 170;
	localparam int HOLD_AT      = 8;
	localparam int HOLD_LEN     = 900;
	localparam int TAIL_CYCLES  = 60;
	localparam int PRINT_CAP    = 50;

	localparam logic [7:0] GGA_TAG [PREFIX_LEN] =
		'{CH_DOLLAR, CH_G, CH_P, CH_G, CH_G, CH_A};

	logic clk = 1'b0;
	logic arst_n;

	ngfe_in_if  rx_ch();
	ngfe_out_if res_ch();

	nmea_gga_field_extractor_unit dut (
		.clk   (clk),
		.arst_n(arst_n),
		.rx    (rx_ch),
		.res   (res_ch)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// parser model state
	logic [2:0] tag_pos;
	logic       tag_ok;
	logic [3:0] field_no;
	len_t       buf_len [NUM_BUFS];
	logic       buf_lost [NUM_BUFS];
	logic [7:0] buf_chars [STORE_DEPTH];

	logic [7:0]  sentence_bytes [$];
	glyph_t      pending_chars [$];

	int unsigned errors;
	int unsigned bytes_taken;
	int unsigned bursts_closed;
	int unsigned results_seen;
	int unsigned trunc_seen;
	int unsigned empty_seen;

	int unsigned src_wait;
	int unsigned src_calm;
	int unsigned sink_wait;
	int unsigned sink_calm;
	logic        nxt_valid;
	logic [7:0]  nxt_byte;
	logic        nxt_ready;
	glyph_t      want;

	task automatic flag_mismatch(input string what, input int unsigned got,
		input int unsigned exp_val);
		errors++;
		if (errors <= PRINT_CAP) begin
			$display("%0t mismatch: %s got 0x%0h want 0x%0h", $realtime, what, got, exp_val);
		end
	endtask

	function automatic int unsigned draw_pause(inout int unsigned calm_left);
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) begin
			calm_left = $urandom_range(8, 40);
			return 0;
		end
		return $urandom_range(0, 14);
	endfunction

	// model of one accepted byte; closes a sentence into pending_chars on '*'
	task automatic parse_gga_byte(input logic [7:0] c);
		glyph_t      g;
		int unsigned n;
		int unsigned k;
		int          slot;
		if (c == CH_DOLLAR) begin
			tag_pos  = 3'd1;
			tag_ok   = 1'b0;
			field_no = 4'd0;
			for (int b = 0; b < NUM_BUFS; b++) begin
				buf_len[b]  = '0;
				buf_lost[b] = 1'b0;
			end
			return;
		end
		if (tag_pos == 3'd0) begin
			return;
		end
		if (!tag_ok) begin
			if (tag_pos < PREFIX_LEN && c == GGA_TAG[tag_pos]) begin
				tag_pos++;
				if (tag_pos == PREFIX_LEN) begin
					tag_ok = 1'b1;
				end
			end else begin
				tag_pos = 3'd0;
			end
			return;
		end
		if (c == CH_STAR) begin
			n = 0;
			for (int b = 0; b < NUM_BUFS; b++) begin
				n += (buf_len[b] == 0) ? 1 : int'(buf_len[b]);
			end
			k = 0;
			for (int b = 0; b < NUM_BUFS; b++) begin
				g.fid   = buf_id_t'(b);
				g.trunc = buf_lost[b];
				if (buf_len[b] == 0) begin
					k++;
					g.code = CH_NUL;
					g.cv   = 1'b0;
					g.last = (k == n);
					pending_chars.push_back(g);
				end else begin
					for (int i = 0; i < buf_len[b]; i++) begin
						k++;
						g.code = buf_chars[b * FIELD_CHARS + i];
						g.cv   = 1'b1;
						g.last = (k == n);
						pending_chars.push_back(g);
					end
				end
			end
			bursts_closed++;
			tag_pos = 3'd0;
			tag_ok  = 1'b0;
			return;
		end
		if (c == CH_COMMA) begin
			if (field_no < FIELD_MAX) begin
				field_no++;
			end
			return;
		end
		case (field_no)
			FIELD_LAT: slot = BUF_LAT;
			FIELD_LON: slot = BUF_LON;
			FIELD_ALT, FIELD_UNIT: slot = BUF_ALT;
			default: slot = -1;
		endcase
		if (slot >= 0) begin
			if (buf_len[slot] < FIELD_CHARS) begin
				buf_chars[slot * FIELD_CHARS + buf_len[slot]] = c;
				buf_len[slot]++;
			end else begin
				buf_lost[slot] = 1'b1;
			end
		end
	endtask

	function automatic logic [7:0] field_char();
		logic [7:0] c;
		do begin
			c = 8'($urandom_range(0, 255));
		end while (c == CH_DOLLAR || c == CH_STAR || c == CH_COMMA);
		return c;
	endfunction

	function automatic logic [7:0] noise_byte();
		int unsigned pick;
		pick = $urandom_range(0, 5);
		if (pick == 0) begin
			return CH_STAR;
		end
		if (pick == 1) begin
			return CH_COMMA;
		end
		return field_char();
	endfunction

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++) begin
			sentence_bytes.push_back(s[i]);
		end
	endtask

	task automatic add_sentence(input gga_kind_e kind);
		int unsigned nfields;
		int unsigned cut;
		int unsigned flen;
		int unsigned brk;
		logic        captured;
		logic [7:0]  c;
		sentence_bytes.push_back(CH_DOLLAR);
		if (kind == KIND_BAD_TAG) begin
			brk = $urandom_range(1, PREFIX_LEN - 1);
			for (int k = 1; k < brk; k++) begin
				sentence_bytes.push_back(GGA_TAG[k]);
			end
			do begin
				c = noise_byte();
			end while (c == GGA_TAG[brk]);
			sentence_bytes.push_back(c);
			repeat ($urandom_range(2, 10)) sentence_bytes.push_back(noise_byte());
			return;
		end
		for (int k = 1; k < PREFIX_LEN; k++) begin
			sentence_bytes.push_back(GGA_TAG[k]);
		end
		nfields = (kind == KIND_MANY) ? $urandom_range(16, 18) : $urandom_range(11, 13);
		cut = (kind == KIND_ABORT) ? $urandom_range(0, nfields - 1) : nfields;
		for (int f = 0; f < nfields; f++) begin
			// a sentence cut short is dropped by the next '$'
			if (f == cut) begin
				return;
			end
			if (f > 0) begin
				sentence_bytes.push_back(CH_COMMA);
			end
			captured = (f == FIELD_LAT || f == FIELD_LON || f == FIELD_ALT || f == FIELD_UNIT);
			if (kind == KIND_LONG && (f == FIELD_LAT || f == FIELD_ALT)) begin
				flen = $urandom_range(15, 19);
			end else if (captured) begin
				flen = $urandom_range(0, 5);
			end else begin
				flen = $urandom_range(0, 1);
			end
			repeat (flen) sentence_bytes.push_back(field_char());
		end
		sentence_bytes.push_back(CH_STAR);
		repeat (2) sentence_bytes.push_back(field_char());
		if (kind == KIND_TAIL) begin
			repeat ($urandom_range(3, 8)) sentence_bytes.push_back(noise_byte());
		end
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_ch.valid   <= 1'b0;
			rx_ch.rx_byte <= '0;
			src_wait = 0;
			src_calm = 0;
		end else begin
			nxt_valid = rx_ch.valid;
			nxt_byte  = rx_ch.rx_byte;
			if (rx_ch.valid && rx_ch.ready) begin
				parse_gga_byte(rx_ch.rx_byte);
				bytes_taken++;
				nxt_valid = 1'b0;
				src_wait  = draw_pause(src_calm);
			end
			if (!nxt_valid) begin
				if (src_wait > 0) begin
					src_wait--;
				end else if (sentence_bytes.size() > 0) begin
					nxt_valid = 1'b1;
					nxt_byte  = sentence_bytes.pop_front();
				end
			end
			rx_ch.valid   <= nxt_valid;
			rx_ch.rx_byte <= nxt_byte;
		end
	end

	// result monitor with ready backpressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			sink_wait = 0;
			sink_calm = 0;
		end else begin
			nxt_ready = res_ch.ready;
			if (res_ch.valid && res_ch.ready) begin
				results_seen++;
				if (pending_chars.size() == 0) begin
					flag_mismatch("result with nothing pending, char", 32'(res_ch.char_code), 0);
				end else begin
					want = pending_chars.pop_front();
					if (res_ch.field_id !== want.fid) begin
						flag_mismatch("field_id", 32'(res_ch.field_id), 32'(want.fid));
					end
					if (res_ch.char_code !== want.code) begin
						flag_mismatch("char_code", 32'(res_ch.char_code), 32'(want.code));
					end
					if (res_ch.char_valid !== want.cv) begin
						flag_mismatch("char_valid", 32'(res_ch.char_valid), 32'(want.cv));
					end
					if (res_ch.truncated !== want.trunc) begin
						flag_mismatch("truncated", 32'(res_ch.truncated), 32'(want.trunc));
					end
					if (res_ch.last !== want.last) begin
						flag_mismatch("last", 32'(res_ch.last), 32'(want.last));
					end
					if (want.trunc) begin
						trunc_seen++;
					end
					if (!want.cv) begin
						empty_seen++;
					end
				end
				nxt_ready = 1'b0;
				// one long hold so both store banks fill and rx stalls
				sink_wait = (results_seen == HOLD_AT) ? HOLD_LEN : draw_pause(sink_calm);
			end
			if (!nxt_ready) begin
				if (sink_wait > 0) begin
					sink_wait--;
				end else begin
					nxt_ready = 1'b1;
				end
			end
			res_ch.ready <= nxt_ready;
		end
	end

	initial begin
		rx_ch.valid   = 1'b0;
		rx_ch.rx_byte = '0;
		res_ch.ready  = 1'b0;
		arst_n        = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	initial begin
		#10_000_000;
		$display("nmea_gga_field_extractor_unit_tb: errors");
		$finish;
	end

	initial begin
		int unsigned pick;
		gga_kind_e   kind;
		errors        = 0;
		bytes_taken   = 0;
		bursts_closed = 0;
		results_seen  = 0;
		trunc_seen    = 0;
		empty_seen    = 0;
		tag_pos       = 3'd0;
		tag_ok        = 1'b0;
		field_no      = 4'd0;
		for (int b = 0; b < NUM_BUFS; b++) begin
			buf_len[b]  = '0;
			buf_lost[b] = 1'b0;
		end

		// all-ones and all-zero bytes captured, empty altitude
		push_text("$GPGGA,,");
		sentence_bytes.push_back(8'hFF);
		sentence_bytes.push_back(8'h00);
		push_text(",,Z*");
		// broken prefix, star and comma after it ignored
		push_text("$GPGX*,");
		// partial prefix restarted by the next dollar
		push_text("$GP");

		// one sentence of each special kind, then random ones up to the budget
		for (int k = 1; k < 6; k++) begin
			add_sentence(gga_kind_e'(k));
		end
		while (sentence_bytes.size() < BYTE_BUDGET) begin
			pick = $urandom_range(0, 9);
			kind = (pick < 5) ? KIND_PLAIN : gga_kind_e'(pick - 4);
			add_sentence(kind);
		end

		@(posedge arst_n);
		while (sentence_bytes.size() > 0 || rx_ch.valid) @(posedge clk);
		while (pending_chars.size() > 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("run covered %0d bytes, %0d closed sentences, %0d characters checked",
			bytes_taken, bursts_closed, results_seen);
		$display("of those %0d were truncated and %0d marked empty fields",
			trunc_seen, empty_seen);
		if (errors == 0) begin
			$display("nmea_gga_field_extractor_unit_tb: clean");
		end else begin
			$display("nmea_gga_field_extractor_unit_tb: errors");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+src
src/ngfe_pkg.sv
src/ngfe_in_if.sv
src/ngfe_out_if.sv
src/ngfe_front.sv
src/ngfe_cmd_fifo.sv
src/ngfe_back.sv
src/nmea_gga_field_extractor_unit.sv
verif/nmea_gga_field_extractor_unit_tb.sv
